FILE: design/ufd_pkg.sv
// shared types, constants and crc function for the update frame deframer
`default_nettype none

package ufd_pkg;

  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 16;
  localparam int IDX_W    = 17;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 8;

  typedef logic [BYTE_W-1:0] ufd_byte_t;
  typedef logic [LEN_W-1:0]  ufd_len_t;
  typedef logic [IDX_W-1:0]  ufd_idx_t;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_FRAME = 2'd1
  } ufd_phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GOOD       = 3'd0,
    ST_INCOMPLETE = 3'd1,
    ST_RESERVED   = 3'd2,
    ST_LENGTH     = 3'd3,
    ST_CRC        = 3'd4
  } ufd_status_t;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REPORT  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_CODE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVE   = 8'd1;

  // frame byte positions
  localparam ufd_idx_t IDX_SLAVE    = 17'd1;
  localparam ufd_idx_t IDX_TYPE     = 17'd2;
  localparam ufd_idx_t IDX_RES_A    = 17'd3;
  localparam ufd_idx_t IDX_RES_B    = 17'd4;
  localparam ufd_idx_t IDX_LEN_HI   = 17'd5;
  localparam ufd_idx_t IDX_LEN_LO   = 17'd6;
  localparam ufd_idx_t IDX_RES_C    = 17'd7;
  localparam ufd_idx_t IDX_CMD      = 17'd8;
  localparam ufd_idx_t IDX_RES_D    = 17'd9;
  localparam ufd_idx_t IDX_FIRST_PL = 17'd10;
  localparam ufd_idx_t IDX_HDR_LAST = 17'd11;
  localparam ufd_idx_t FLEN_NO_PL   = IDX_HDR_LAST + 17'd1;

  localparam ufd_len_t LEN_OVERHEAD = 16'd5;
  localparam ufd_idx_t LEN_BASE     = 17'd7;

  localparam ufd_len_t CRC_INIT = 16'hFFFF;
  localparam ufd_len_t CRC_POLY = 16'hA001;

  typedef struct packed {
    ufd_byte_t data_byte;
    logic      buffer_end;
  } ufd_item_t;

  typedef struct packed {
    logic        result_kind;
    ufd_byte_t   payload_byte;
    ufd_status_t status;
    ufd_byte_t   node_addr;
    ufd_byte_t   ic_type;
    ufd_byte_t   command;
    ufd_len_t    body_len;
    ufd_len_t    received_crc;
  } ufd_result_t;

  // modbus crc16, one byte, reflected
  function automatic ufd_len_t crc16_byte(input ufd_len_t crc_in, input ufd_byte_t b);
    ufd_len_t c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: design/ufd_channels.sv
// valid/ready channel interfaces for byte input, results and register writes
`default_nettype none

interface ufd_in_if;
  logic                     valid;
  logic                     ready;
  logic [ufd_pkg::BYTE_W-1:0] data_byte;
  logic                     buffer_end;

  modport source (output valid, output data_byte, output buffer_end, input ready);
  modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface ufd_out_if;
  logic                         valid;
  logic                         ready;
  logic                         result_kind;
  logic [ufd_pkg::BYTE_W-1:0]   payload_byte;
  logic [ufd_pkg::STATUS_W-1:0] status;
  logic [ufd_pkg::BYTE_W-1:0]   node_addr;
  logic [ufd_pkg::BYTE_W-1:0]   ic_type;
  logic [ufd_pkg::BYTE_W-1:0]   command;
  logic [ufd_pkg::LEN_W-1:0]    body_len;
  logic [ufd_pkg::LEN_W-1:0]    received_crc;

  modport source (output valid, output result_kind, output payload_byte, output status,
                  output node_addr, output ic_type, output command, output body_len,
                  output received_crc, input ready);
  modport sink   (input valid, input result_kind, input payload_byte, input status,
                  input node_addr, input ic_type, input command, input body_len,
                  input received_crc, output ready);
endinterface

interface ufd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ufd_pkg::CFG_IDX_W-1:0] index;
  logic [ufd_pkg::BYTE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: design/ufd_parser.sv
// frame parse stage: hunt, header capture, payload forwarding, crc and end-of-frame report
`default_nettype none

module ufd_parser (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                go,
  input  wire ufd_pkg::ufd_byte_t  head_code,
  input  wire ufd_pkg::ufd_byte_t  reserve_value,
  input  wire ufd_pkg::ufd_item_t  item,
  output logic                     res_valid,
  output ufd_pkg::ufd_result_t     result
);
  import ufd_pkg::*;

  ufd_phase_t phase_r, phase_nxt;
  ufd_idx_t   idx_r, idx_nxt;
  ufd_len_t   crc_r, crc_nxt;
  ufd_len_t   len_r, len_nxt;
  ufd_byte_t  slave_r, slave_nxt;
  ufd_byte_t  type_r, type_nxt;
  ufd_byte_t  cmd_r, cmd_nxt;
  logic       res_ok_r, res_ok_nxt;
  ufd_byte_t  first_r, first_nxt;

  ufd_byte_t  b;
  logic       last;
  ufd_idx_t   flen;
  ufd_idx_t   idx_plus2;
  logic       hunting, hit, in_hdr, at_check, res_bad, len_bad;
  logic       body, body_data, body_crc1, body_end;
  ufd_len_t   crc_be, crc_le, crc_step;
  logic       crc_ok, first_pl_fwd, report, fwd;
  ufd_status_t status;

  assign b         = item.data_byte;
  assign last      = item.buffer_end;
  assign flen      = {1'b0, len_r} + LEN_BASE;
  assign idx_plus2 = idx_r + 17'd2;

  assign hunting  = (phase_r == PH_HUNT);
  assign hit      = hunting && (b == head_code);
  assign in_hdr   = !hunting && (idx_r < IDX_HDR_LAST);
  assign at_check = !hunting && (idx_r == IDX_HDR_LAST);
  // reserved mismatch wins over a short length
  assign res_bad  = at_check && !res_ok_r;
  assign len_bad  = at_check && res_ok_r && (len_r < LEN_OVERHEAD);

  assign body      = !hunting && !in_hdr && !res_bad && !len_bad;
  assign body_data = body && (idx_plus2 < flen);
  assign body_crc1 = body && (idx_plus2 == flen);
  assign body_end  = body && (idx_plus2 > flen);

  assign crc_be   = {first_r, b};
  assign crc_le   = {b, first_r};
  assign crc_ok   = (crc_be == crc_r) || (crc_le == crc_r);
  assign crc_step = crc16_byte(hunting ? CRC_INIT : crc_r, b);

  // byte 10 is payload only when the frame is longer than the bare header
  assign first_pl_fwd = in_hdr && (idx_r == IDX_FIRST_PL) && (flen > FLEN_NO_PL)
                        && res_ok_r && !last;

  assign report = (hit && last) || (in_hdr && last) || res_bad || len_bad
                  || ((body_data || body_crc1) && last) || body_end;
  assign fwd    = first_pl_fwd || (body_data && !last);

  always_comb begin
    if (hit || in_hdr) begin
      status = ST_INCOMPLETE;
    end else if (res_bad) begin
      status = ST_RESERVED;
    end else if (len_bad) begin
      status = ST_LENGTH;
    end else if (body_end) begin
      status = crc_ok ? ST_GOOD : ST_CRC;
    end else begin
      status = ST_LENGTH;
    end
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_HUNT: begin
        if (hit && !last) phase_nxt = PH_FRAME;
      end
      PH_FRAME: begin
        if (report) phase_nxt = PH_HUNT;
      end
      default: phase_nxt = PH_HUNT;
    endcase
  end

  // frame context next values
  always_comb begin
    idx_nxt    = idx_r;
    crc_nxt    = crc_r;
    len_nxt    = len_r;
    slave_nxt  = slave_r;
    type_nxt   = type_r;
    cmd_nxt    = cmd_r;
    res_ok_nxt = res_ok_r;
    first_nxt  = first_r;
    if (report) begin
      idx_nxt    = '0;
      crc_nxt    = CRC_INIT;
      len_nxt    = '0;
      slave_nxt  = '0;
      type_nxt   = '0;
      cmd_nxt    = '0;
      res_ok_nxt = 1'b1;
      first_nxt  = '0;
    end else if (hit) begin
      idx_nxt = IDX_SLAVE;
      crc_nxt = crc_step;
    end else if (in_hdr) begin
      idx_nxt = idx_r + 17'd1;
      case (idx_r)
        IDX_SLAVE:  slave_nxt = b;
        IDX_TYPE:   type_nxt  = b;
        IDX_RES_A, IDX_RES_B, IDX_RES_C, IDX_RES_D: begin
          if (b != reserve_value) res_ok_nxt = 1'b0;
        end
        IDX_LEN_HI: len_nxt[15:8] = b;
        IDX_LEN_LO: len_nxt[7:0]  = b;
        IDX_CMD:    cmd_nxt   = b;
        default: ;
      endcase
      if (idx_r == IDX_FIRST_PL) begin
        if (flen > FLEN_NO_PL) begin
          crc_nxt = crc_step;
        end else if (flen == FLEN_NO_PL) begin
          first_nxt = b;
        end
      end else begin
        crc_nxt = crc_step;
      end
    end else if (body_data) begin
      idx_nxt = idx_r + 17'd1;
      crc_nxt = crc_step;
    end else if (body_crc1) begin
      idx_nxt   = idx_r + 17'd1;
      first_nxt = b;
    end
  end

  // result fields
  always_comb begin
    result             = '0;
    result.status      = ST_GOOD;
    result.result_kind = report ? KIND_REPORT : KIND_PAYLOAD;
    if (fwd) begin
      result.payload_byte = b;
    end
    if (report) begin
      result.status = status;
      if (status == ST_GOOD) begin
        result.node_addr    = slave_r;
        result.ic_type      = type_r;
        result.command      = cmd_r;
        result.body_len     = len_r - LEN_OVERHEAD;
        result.received_crc = crc_be;
      end
    end
  end

  assign res_valid = report || fwd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      idx_r    <= '0;
      crc_r    <= CRC_INIT;
      len_r    <= '0;
      slave_r  <= '0;
      type_r   <= '0;
      cmd_r    <= '0;
      res_ok_r <= 1'b1;
      first_r  <= '0;
    end else if (go) begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      crc_r    <= crc_nxt;
      len_r    <= len_nxt;
      slave_r  <= slave_nxt;
      type_r   <= type_nxt;
      cmd_r    <= cmd_nxt;
      res_ok_r <= res_ok_nxt;
      first_r  <= first_nxt;
    end
  end

  a_report_rehunts: assert property (@(posedge clk) disable iff (!rst_n)
    go && res_valid && (result.result_kind == KIND_REPORT) |=> (phase_r == PH_HUNT))
    else $error("parser did not return to hunting after a report");

  a_hunt_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HUNT) |-> (idx_r == '0) && (crc_r == CRC_INIT) && res_ok_r)
    else $error("frame context not cleared while hunting");

  a_frame_index: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_FRAME) |-> (idx_r != '0))
    else $error("byte index zero inside a frame");

  a_bad_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && (result.status != ST_GOOD) |->
      (result.node_addr == '0) && (result.body_len == '0) && (result.received_crc == '0))
    else $error("failed report carries frame fields");

  a_fwd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(fwd && report))
    else $error("payload forward and report in the same byte");

endmodule

`default_nettype wire

FILE: design/update_frame_deframer_top.sv
// top level: input register, frame parse stage, result register, config registers
// a result passes from the input register through the parse stage into the result register
// throughput: one byte per cycle while the output channel takes results; the byte-wise crc update in the parse stage
//   sets the cycle
// reset (synchronous, rst_n low): config registers cleared to zero, parser hunting for the
//   head code with the crc preset, input and result registers empty
`default_nettype none

module update_frame_deframer_top (
  input wire logic  clk,
  input wire logic  rst_n,
  ufd_in_if.sink    in_chan,
  ufd_out_if.source out_chan,
  ufd_cfg_if.sink   cfg_chan
);
  import ufd_pkg::*;

  ufd_byte_t   head_code_r;
  ufd_byte_t   reserve_r;
  logic        s1_v_r;
  ufd_item_t   s1_item_r;
  logic        out_v_r;
  ufd_result_t out_r;

  logic        adv;
  logic        res_valid;
  ufd_result_t result;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_code_r <= '0;
      reserve_r   <= '0;
    end else if (cfg_chan.valid) begin
      if (cfg_chan.index == CFG_HEAD_CODE) head_code_r <= cfg_chan.data;
      if (cfg_chan.index == CFG_RESERVE)   reserve_r   <= cfg_chan.data;
    end
  end

  // parse stage moves when the result register is free or being drained
  assign adv           = s1_v_r && (!out_v_r || out_chan.ready);
  assign in_chan.ready = !s1_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_item_r.data_byte  <= in_chan.data_byte;
      s1_item_r.buffer_end <= in_chan.buffer_end;
    end
  end

  ufd_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .go            (adv),
    .head_code     (head_code_r),
    .reserve_value (reserve_r),
    .item          (s1_item_r),
    .res_valid     (res_valid),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= res_valid;
    end else if (out_chan.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      out_r <= result;
    end
  end

  assign out_chan.valid        = out_v_r;
  assign out_chan.result_kind  = out_r.result_kind;
  assign out_chan.payload_byte = out_r.payload_byte;
  assign out_chan.status       = out_r.status;
  assign out_chan.node_addr    = out_r.node_addr;
  assign out_chan.ic_type      = out_r.ic_type;
  assign out_chan.command      = out_r.command;
  assign out_chan.body_len     = out_r.body_len;
  assign out_chan.received_crc = out_r.received_crc;

endmodule

`default_nettype wire
